### hdl/sgd_pkg.sv
// Shared types and constants for the signed Golomb bit decoder.
// Used by the front parser, the codeword queue, the back end and the top level.
package sgd_pkg;

  // The divisor magnitude saturates at 2^DIVISOR_BITS - 1.
  localparam int DIVISOR_BITS = 15;
  localparam logic [31:0] MAG_LIM = 32'((64'd1 << DIVISOR_BITS) - 64'd1);

  // Widths of the divisor magnitude, the modulus and the code length.
  localparam int MAG_W = 17;
  localparam int MOD_W = 17;
  localparam int LEN_W = $clog2(MOD_W + 1);

  // Width of the decoded value and of the quotient counter.
  localparam int VAL_W = 32;

  // Depth of the queues between front and back and at the output.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Parser phase.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_QUOT  = 2'd1,
    PH_REM   = 2'd2,
    PH_EXTRA = 2'd3
  } phase_t;

  // One parsed codeword: value = quot * modulus + rest, or a failure when ok is low.
  typedef struct packed {
    logic [VAL_W-1:0] quot;
    logic [MOD_W-1:0] modulus;
    logic [MOD_W-1:0] rest;
    logic             ok;
  } cw_t;

  // Handshake group from the parser into the codeword queue.
  typedef struct packed {
    logic valid;
    cw_t  cw;
  } cw_push_t;

  // One finished result word.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             ok;
  } res_t;

endpackage

### hdl/signed_golomb_bit_decoder_core.sv
// Signed Golomb bit decoder. One code bit enters per clock while in_full is low, so a
// stream of bits is taken back to back. A result word for a finished codeword, or for a
// stream end inside a codeword, passes from the parser through the codeword queue and the
// 32x17 multiplier stage into the output queue, which it enters only when that queue has
// room. Four-entry queues between the parser and the multiplier and at the output let
// either side stall on its own; in_full rises only when the codeword queue is full.
// Depends on sgd_pkg, sgd_front, sgd_queue and sgd_back.
module signed_golomb_bit_decoder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_code_bit,
  input  logic                            in_stream_end,
  input  logic signed [15:0]              in_divisor,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic signed [sgd_pkg::VAL_W-1:0] out_decoded_value,
  output logic                            out_ok
);
  import sgd_pkg::*;

  cw_push_t push;
  logic     take;
  logic     q_valid;
  cw_t      q_head;
  logic     q_pop;
  res_t     res;

  assign take = in_push && !in_full;

  // Front: bit parser.
  sgd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .code_bit   (in_code_bit),
    .stream_end (in_stream_end),
    .divisor    (in_divisor),
    .push       (push)
  );

  // Codeword queue between front and back.
  sgd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (in_full),
    .valid (q_valid),
    .head  (q_head),
    .pop   (q_pop)
  );

  // Back: value computation and output queue.
  sgd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cw_valid  (q_valid),
    .cw        (q_head),
    .cw_pop    (q_pop),
    .res_empty (out_empty),
    .res       (res),
    .res_pop   (out_pop)
  );

  assign out_decoded_value = $signed(res.value);
  assign out_ok            = res.ok;

endmodule

### hdl/sgd_front.sv
// Bit parser: tracks the phase of the current codeword and emits parsed codewords.
// Depends on sgd_pkg.
module sgd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic                 code_bit,
  input  logic                 stream_end,
  input  logic signed [15:0]   divisor,
  output sgd_pkg::cw_push_t    push
);
  import sgd_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [VAL_W-1:0] quot_r, quot_nxt;
  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [MOD_W-1:0] mod_r, mod_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [MOD_W-1:0] lim_r, lim_nxt;

  logic [MAG_W-1:0] div_sx;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] mag_sat;
  logic [MOD_W-1:0] new_mod;
  logic [LEN_W-1:0] new_len;
  logic [MOD_W-1:0] new_lim;

  // Modulus and code parameters derived from the divisor on the first bit.
  always_comb begin
    div_sx = {divisor[15], divisor};
    mag    = div_sx[MAG_W-1] ? (~div_sx + MAG_W'(1)) : div_sx;
    mag_sat = mag;
    if (mag == '0) begin
      mag_sat = MAG_W'(1);
    end
    if (32'(mag_sat) > MAG_LIM) begin
      mag_sat = MAG_LIM[MAG_W-1:0];
    end
    new_mod = {mag_sat[MOD_W-2:0], 1'b0};
    new_len = '0;
    for (int i = 0; i < MOD_W; i++) begin
      if ((MOD_W'(1) << i) < new_mod) begin
        new_len = LEN_W'(i + 1);
      end
    end
    new_lim = MOD_W'(((MOD_W + 1)'(1) << new_len) - {1'b0, new_mod});
  end

  // Next-state logic of the parser.
  always_comb begin
    phase_t           cur_phase;
    logic [VAL_W-1:0] q_cur;
    logic [MOD_W-1:0] m_cur;
    logic [LEN_W-1:0] b_cur;
    logic [MOD_W-1:0] t_cur;
    logic [MOD_W-1:0] r_new;
    logic [MOD_W-1:0] rest;
    logic             do_decide;
    logic             emit;

    phase_nxt = phase_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    left_nxt  = left_r;
    mod_nxt   = mod_r;
    len_nxt   = len_r;
    lim_nxt   = lim_r;
    push      = '0;
    cur_phase = phase_r;
    q_cur     = quot_r;
    m_cur     = mod_r;
    b_cur     = len_r;
    t_cur     = lim_r;
    r_new     = '0;
    rest      = '0;
    do_decide = 1'b0;
    emit      = 1'b0;

    if (take) begin
      if (stream_end) begin
        // A stream end inside a codeword gives a failure word.
        if (phase_r != PH_IDLE) begin
          push.valid = 1'b1;
          phase_nxt  = PH_IDLE;
          quot_nxt   = '0;
          rem_nxt    = '0;
          left_nxt   = '0;
        end
      end else begin
        // The first bit of a codeword latches the divisor.
        if (phase_r == PH_IDLE) begin
          cur_phase = PH_QUOT;
          q_cur     = '0;
          m_cur     = new_mod;
          b_cur     = new_len;
          t_cur     = new_lim;
          mod_nxt   = new_mod;
          len_nxt   = new_len;
          lim_nxt   = new_lim;
        end
        case (cur_phase)
          PH_QUOT: begin
            if (code_bit) begin
              quot_nxt  = q_cur + VAL_W'(1);
              phase_nxt = PH_QUOT;
            end else begin
              quot_nxt = q_cur;
              rem_nxt  = '0;
              left_nxt = b_cur - LEN_W'(1);
              if (b_cur == LEN_W'(1)) begin
                do_decide = 1'b1;
              end else begin
                phase_nxt = PH_REM;
              end
            end
          end
          PH_REM: begin
            r_new    = {rem_r[MOD_W-2:0], code_bit};
            rem_nxt  = r_new;
            left_nxt = left_r - LEN_W'(1);
            if (left_r == LEN_W'(1)) begin
              do_decide = 1'b1;
            end
          end
          PH_EXTRA: begin
            rest = {rem_r[MOD_W-2:0], code_bit} - t_cur;
            emit = 1'b1;
          end
          default: begin
          end
        endcase

        // Short codes end here; long ones take one more bit.
        if (do_decide) begin
          if (r_new < t_cur) begin
            rest = r_new;
            emit = 1'b1;
          end else begin
            rem_nxt   = r_new;
            phase_nxt = PH_EXTRA;
          end
        end

        if (emit) begin
          push.valid      = 1'b1;
          push.cw.quot    = q_cur;
          push.cw.modulus = m_cur;
          push.cw.rest    = rest;
          push.cw.ok      = 1'b1;
          phase_nxt       = PH_IDLE;
          quot_nxt        = '0;
          rem_nxt         = '0;
          left_nxt        = '0;
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      quot_r  <= '0;
      rem_r   <= '0;
      left_r  <= '0;
      mod_r   <= MOD_W'(2);
      len_r   <= LEN_W'(1);
      lim_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      quot_r  <= quot_nxt;
      rem_r   <= rem_nxt;
      left_r  <= left_nxt;
      mod_r   <= mod_nxt;
      len_r   <= len_nxt;
      lim_r   <= lim_nxt;
    end
  end

endmodule

### hdl/sgd_queue.sv
// Short queue of parsed codewords between the parser and the back end.
// Depends on sgd_pkg.
module sgd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  sgd_pkg::cw_push_t push,
  output logic              full,
  output logic              valid,
  output sgd_pkg::cw_t      head,
  input  logic              pop
);
  import sgd_pkg::*;

  cw_t               mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem[rd_r];
  assign do_wr = push.valid && !full;
  assign do_rd = pop && valid;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = do_wr ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_rd ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_r] <= push.cw;
    end
  end

endmodule

### hdl/sgd_back.sv
// Back end: multiplies out the quotient, adds the rest, unmaps the zigzag value
// and queues finished words for the output. Depends on sgd_pkg.
module sgd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cw_valid,
  input  sgd_pkg::cw_t      cw,
  output logic              cw_pop,
  output logic              res_empty,
  output sgd_pkg::res_t     res,
  input  logic              res_pop
);
  import sgd_pkg::*;

  // Product stage.
  logic             s1_v_r, s1_v_nxt;
  logic [VAL_W-1:0] prod_r;
  logic [MOD_W-1:0] rest_r;
  logic             ok_r;

  // Output queue.
  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              ofull;
  logic              do_wr;
  logic              do_rd;
  logic              s1_ready;
  logic [VAL_W-1:0]  sum;
  res_t              res_new;

  assign ofull     = (cnt_r == QCNT_W'(QDEPTH));
  assign res_empty = (cnt_r == '0);
  assign res       = mem[rd_r];
  assign do_wr     = s1_v_r && !ofull;
  assign do_rd     = res_pop && !res_empty;
  assign s1_ready  = !s1_v_r || !ofull;
  assign cw_pop    = cw_valid && s1_ready;

  // Add the rest and undo the zigzag mapping.
  always_comb begin
    sum           = prod_r + VAL_W'(rest_r);
    res_new.value = sum[0] ? ~(sum >> 1) : (sum >> 1);
    res_new.ok    = ok_r;
  end

  // Control of the product stage and the output queue.
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_ready) begin
      s1_v_nxt = cw_valid;
    end
    wr_nxt  = do_wr ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_rd ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Product register; the value wraps at 32 bits.
  always_ff @(posedge clk) begin
    if (cw_pop) begin
      prod_r <= cw.quot * VAL_W'(cw.modulus);
      rest_r <= cw.rest;
      ok_r   <= cw.ok;
    end
  end

  // Output queue storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_r] <= res_new;
    end
  end

endmodule
